// ===== rtl/tlbpt_pkg.sv =====
// Shared constants for the TLB / page table translator.
// No dependencies; used by the top level, the checkers and the testbench.

package tlbpt_pkg;

    // Fixed width of the logical and physical address ports
    localparam int ADDR_W = 16;

    // Default geometry (all must be powers of two)
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int PAGE_SIZE_DEF   = 256;

endpackage

// ===== rtl/tlb_page_table_translator.sv =====
// Top level of the TLB / demand-paged page table address translator.
// Uses tlbpt_pkg, tlbpt_tlb and tlbpt_pmap.
//
//  channel  direction  handshake                payload
//  in       to block   i_in_valid / o_in_stall   i_logical_address
//  out      from block o_out_valid / i_out_stall o_phys_addr, o_tlb_hit, o_page_fault
//
// An accepted address issues the page table read and stalls the input; the
// resolve state then resolves hit/fault, writes back and loads the output register.
// After reset a clearing pass empties the page table (input stalled).
// A result waiting on i_out_stall does not block the next accept; that item
// holds in the resolve stage until the output register frees.
// PAGE_COUNT, PAGE_SIZE and TLB_ENTRIES must be powers of two.

module tlb_page_table_translator #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_SIZE   = tlbpt_pkg::PAGE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0] i_logical_address,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tlbpt_pkg::ADDR_W-1:0] o_phys_addr,
    output logic                         o_tlb_hit,
    output logic                         o_page_fault
);

    localparam int OFF_W  = $clog2(PAGE_SIZE);
    localparam int PAGE_W = $clog2(PAGE_COUNT);

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } t_state;

    t_state                       r_state;
    logic [PAGE_W-1:0]            r_page;
    logic [OFF_W-1:0]             r_offset;
    logic                         r_out_valid;
    logic [tlbpt_pkg::ADDR_W-1:0] r_phys;
    logic                         r_hit;
    logic                         r_fault;

    logic [31:0]                  addr_ext;
    logic [PAGE_W-1:0]            in_page;
    logic                         in_acc;
    logic                         out_free;
    logic                         complete;
    logic                         pm_ready;
    logic                         pm_mapped;
    logic [PAGE_W-1:0]            pm_frame;
    logic [PAGE_W-1:0]            pm_next;
    logic                         tlb_hit;
    logic [PAGE_W-1:0]            tlb_frame;
    logic                         fault;
    logic [PAGE_W-1:0]            frame;
    logic [31:0]                  phys_full;

    // split the address: offset low, page above it wrapped to PAGE_COUNT
    assign addr_ext = 32'(i_logical_address);
    assign in_page  = addr_ext[OFF_W +: PAGE_W];

    // handshake: one transaction in flight until it resolves
    assign o_in_stall = !pm_ready || (r_state == S_RESOLVE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign complete   = (r_state == S_RESOLVE) && out_free;

    // resolve: TLB first, then page table, allocating on a fault
    assign fault = !tlb_hit && !pm_mapped;
    always_comb begin
        if (tlb_hit) begin
            frame = tlb_frame;
        end else if (pm_mapped) begin
            frame = pm_frame;
        end else begin
            frame = pm_next;
        end
    end
    assign phys_full = (32'(frame) << OFF_W) | 32'(r_offset);

    tlbpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_W      (PAGE_W)
    ) u_tlb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_lookup_page (r_page),
        .o_hit         (tlb_hit),
        .o_frame       (tlb_frame),
        .i_ins_en      (complete && !tlb_hit),
        .i_ins_page    (r_page),
        .i_ins_frame   (frame)
    );

    tlbpt_pmap #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_W     (PAGE_W)
    ) u_pmap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (in_acc),
        .i_rd_page    (in_page),
        .o_rd_mapped  (pm_mapped),
        .o_rd_frame   (pm_frame),
        .i_alloc_en   (complete && fault),
        .i_alloc_page (r_page),
        .o_next_frame (pm_next),
        .o_ready      (pm_ready)
    );

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state  <= S_RESOLVE;
                        r_page   <= in_page;
                        r_offset <= i_logical_address[OFF_W-1:0];
                    end
                end
                S_RESOLVE: begin
                    if (complete) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (complete) begin
                r_out_valid <= 1'b1;
                r_phys      <= phys_full[tlbpt_pkg::ADDR_W-1:0];
                r_hit       <= tlb_hit;
                r_fault     <= fault;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_phys_addr  = r_phys;
    assign o_tlb_hit    = r_hit;
    assign o_page_fault = r_fault;

endmodule

// ===== rtl/tlbpt_pmap.sv =====
// Demand-paged page table: one synchronous memory of {mapped, frame} words,
// a clearing pass after reset and the in-order free frame allocator.
// Depends on nothing but its parameters.

module tlbpt_pmap #(
    parameter int PAGE_COUNT = 256,
    parameter int PAGE_W     = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // read port, data registered, held until the next read
    input  logic              i_rd_en,
    input  logic [PAGE_W-1:0] i_rd_page,
    output logic              o_rd_mapped,
    output logic [PAGE_W-1:0] o_rd_frame,
    // fault allocation: maps i_alloc_page to o_next_frame
    input  logic              i_alloc_en,
    input  logic [PAGE_W-1:0] i_alloc_page,
    output logic [PAGE_W-1:0] o_next_frame,
    // high once the clearing pass has finished
    output logic              o_ready
);

    logic [PAGE_W:0]   r_mem [PAGE_COUNT];
    logic [PAGE_W:0]   r_rdata;
    logic              r_clr_busy;
    logic [PAGE_W-1:0] r_clr_idx;
    logic [PAGE_W-1:0] r_next_frame;

    // clear pass walks every page once, then the allocator takes over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy   <= 1'b1;
            r_clr_idx    <= '0;
            r_next_frame <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == PAGE_W'(PAGE_COUNT - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            // frames wrap modulo PAGE_COUNT
            if (i_alloc_en) begin
                r_next_frame <= r_next_frame + 1'b1;
            end
        end
    end

    // memory: one write port (clear or allocate), one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_alloc_en) begin
            r_mem[i_alloc_page] <= {1'b1, r_next_frame};
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_page];
        end
    end

    assign o_rd_mapped  = r_rdata[PAGE_W];
    assign o_rd_frame   = r_rdata[PAGE_W-1:0];
    assign o_next_frame = r_next_frame;
    assign o_ready      = !r_clr_busy;

endmodule

// ===== rtl/tlbpt_tlb.sv =====
// Fully associative TLB with fill-first, then FIFO replacement.
// Entries below the fill count are valid; depends only on its parameters.

module tlbpt_tlb #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_W      = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // lookup
    input  logic [PAGE_W-1:0] i_lookup_page,
    output logic              o_hit,
    output logic [PAGE_W-1:0] o_frame,
    // insert
    input  logic              i_ins_en,
    input  logic [PAGE_W-1:0] i_ins_page,
    input  logic [PAGE_W-1:0] i_ins_frame
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam int CNT_W = $clog2(TLB_ENTRIES + 1);

    logic [PAGE_W-1:0] r_page  [TLB_ENTRIES];
    logic [PAGE_W-1:0] r_frame [TLB_ENTRIES];
    logic [CNT_W-1:0]  r_fill;
    logic [IDX_W-1:0]  r_victim;
    logic              full;
    logic [IDX_W-1:0]  slot;

    // parallel compare; lowest matching valid slot wins
    always_comb begin
        o_hit   = 1'b0;
        o_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_fill) && (r_page[i] == i_lookup_page)) begin
                o_hit   = 1'b1;
                o_frame = r_frame[i];
            end
        end
    end

    // slot choice: next empty slot, else the oldest
    assign full = (r_fill == CNT_W'(TLB_ENTRIES));
    assign slot = full ? r_victim : r_fill[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_victim <= '0;
        end else if (i_ins_en) begin
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end else if (r_victim == IDX_W'(TLB_ENTRIES - 1)) begin
                r_victim <= '0;
            end else begin
                r_victim <= r_victim + 1'b1;
            end
        end
    end

    // entry payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ins_en) begin
            r_page[slot]  <= i_ins_page;
            r_frame[slot] <= i_ins_frame;
        end
    end

endmodule

// ===== rtl/tlbpt_checker.sv =====
// Port-level checker for the translator, bound to the top level.
// Depends on tlbpt_pkg and the ports of tlb_page_table_translator.

module tlbpt_port_checker #(
    parameter int PAGE_SIZE = tlbpt_pkg::PAGE_SIZE_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [tlbpt_pkg::ADDR_W-1:0] i_logical_address,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [tlbpt_pkg::ADDR_W-1:0] o_phys_addr,
    input logic                         o_tlb_hit,
    input logic                         o_page_fault
);

    localparam int OFF_W = $clog2(PAGE_SIZE);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one transaction at a time: the cycle after an accept is stalled
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("accept not followed by stall");

    // a transaction whose resolve cycle finds the output free arrives with its offset intact
    a_offset_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc ##1 (!o_out_valid || !i_out_stall) |=>
            o_out_valid && (o_phys_addr[OFF_W-1:0] ==
                            $past(i_logical_address[OFF_W-1:0], 2)))
        else $error("result missing or offset changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_phys_addr) && $stable(o_tlb_hit)
            && $stable(o_page_fault))
        else $error("stalled result changed");

    // a TLB hit never faults
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tlb_hit |-> !o_page_fault)
        else $error("hit and fault together");

endmodule

bind tlb_page_table_translator tlbpt_port_checker #(.PAGE_SIZE(PAGE_SIZE)) u_tlbpt_checker (.*);

// ===== verif/tlbpt_checker.sv =====
// Checker for the TLB / page table translator: watches both channels,
// keeps its own TLB and page table copy and compares every result.
// Depends on tlbpt_pkg.

module tlbpt_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0] i_logical_address,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0] i_phys_addr,
    input  logic                         i_tlb_hit,
    input  logic                         i_page_fault,
    output int                           o_mismatch_count,
    output int                           o_pending,
    output int                           o_translation_count,
    output int                           o_hit_count,
    output int                           o_fault_count
);

    localparam int ADDR_W   = tlbpt_pkg::ADDR_W;
    localparam int ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF;
    localparam int PAGES    = tlbpt_pkg::PAGE_COUNT_DEF;
    localparam int PG_SIZE  = tlbpt_pkg::PAGE_SIZE_DEF;
    localparam int PAGE_W   = $clog2(PAGES);
    localparam int SLOT_W   = $clog2(ENTRIES);

    typedef struct packed {
        logic [ADDR_W-1:0] logical;
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
    } t_translation;

    // Shadow page table
    logic              page_mapped [PAGES];
    logic [PAGE_W-1:0] page_frame  [PAGES];

    // Shadow TLB with its fill and FIFO replacement pointers
    logic              slot_valid [ENTRIES];
    logic [PAGE_W-1:0] slot_page  [ENTRIES];
    logic [PAGE_W-1:0] slot_frame [ENTRIES];
    int unsigned       slots_filled;
    logic [SLOT_W-1:0] oldest_slot;
    logic [PAGE_W-1:0] free_frame;

    t_translation expected_q[$];
    t_translation want;

    // Translate one address and update the shadow TLB and page table
    function automatic t_translation translate_address(input logic [ADDR_W-1:0] logical);
        t_translation      r;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] frame;
        int unsigned       offset;
        int unsigned       slot;
        page     = PAGE_W'((logical / PG_SIZE) % PAGES);
        offset   = logical % PG_SIZE;
        r.logical = logical;
        r.hit    = 1'b0;
        r.fault  = 1'b0;
        frame    = '0;
        // lowest matching valid slot wins
        for (int i = 0; i < ENTRIES; i++) begin
            if (!r.hit && slot_valid[i] && slot_page[i] == page) begin
                frame = slot_frame[i];
                r.hit = 1'b1;
            end
        end
        if (!r.hit) begin
            // unmapped page: demand-allocate the next frame (wraps)
            if (!page_mapped[page]) begin
                r.fault           = 1'b1;
                page_mapped[page] = 1'b1;
                page_frame[page]  = free_frame;
                free_frame        = free_frame + 1'b1;
            end
            frame = page_frame[page];
            // fill empty slots first, then replace oldest
            if (slots_filled < ENTRIES) begin
                slot         = slots_filled;
                slots_filled = slots_filled + 1;
            end else begin
                slot        = oldest_slot;
                oldest_slot = oldest_slot + 1'b1;
            end
            slot_valid[slot] = 1'b1;
            slot_page[slot]  = page;
            slot_frame[slot] = frame;
        end
        r.phys = ADDR_W'(frame * PG_SIZE + offset);
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [ADDR_W-1:0] logical,
                                        input logic [ADDR_W-1:0] exp_val,
                                        input logic [ADDR_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch for logical 0x%04h: expected 0x%0h, actual 0x%0h",
                     $time, field, logical, exp_val, act_val);
            o_mismatch_count++;
        end
    endfunction

    // Channel monitor: outgoing transactions are checked before new ones are queued
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                page_mapped[p] = 1'b0;
            end
            for (int s = 0; s < ENTRIES; s++) begin
                slot_valid[s] = 1'b0;
            end
            slots_filled = 0;
            oldest_slot  = '0;
            free_frame   = '0;
            expected_q.delete();
            o_mismatch_count    = 0;
            o_translation_count = 0;
            o_hit_count         = 0;
            o_fault_count       = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual 0x%04h %0b %0b",
                             $time, i_phys_addr, i_tlb_hit, i_page_fault);
                    o_mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("phys_addr", want.logical, want.phys, i_phys_addr);
                    check_field("tlb_hit", want.logical, ADDR_W'(want.hit),
                                ADDR_W'(i_tlb_hit));
                    check_field("page_fault", want.logical, ADDR_W'(want.fault),
                                ADDR_W'(i_page_fault));
                    o_translation_count++;
                    if (want.hit) o_hit_count++;
                    if (want.fault) o_fault_count++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.push_back(translate_address(i_logical_address));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the translator testbench: clock, reset, address stimulus with
// random gaps and output stalls, watchdog and verdict.
// Depends on tlbpt_pkg, tlb_page_table_translator and tlbpt_checker.

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int ADDR_W         = tlbpt_pkg::ADDR_W;
    localparam int ENTRIES        = tlbpt_pkg::TLB_ENTRIES_DEF;
    localparam int PAGES          = tlbpt_pkg::PAGE_COUNT_DEF;
    localparam int PG_SIZE        = tlbpt_pkg::PAGE_SIZE_DEF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [ADDR_W-1:0] i_logical_address = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [ADDR_W-1:0] o_phys_addr;
    logic              o_tlb_hit;
    logic              o_page_fault;

    int mismatch_count;
    int translations_pending;
    int translation_count;
    int hit_count;
    int fault_count;

    bit          steady_flow = 1'b0;
    int unsigned stall_cycles = 0;
    int unsigned stall_draw;
    int unsigned idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    tlb_page_table_translator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_logical_address (i_logical_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_phys_addr       (o_phys_addr),
        .o_tlb_hit         (o_tlb_hit),
        .o_page_fault      (o_page_fault)
    );

    tlbpt_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_logical_address   (i_logical_address),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_phys_addr         (o_phys_addr),
        .i_tlb_hit           (o_tlb_hit),
        .i_page_fault        (o_page_fault),
        .o_mismatch_count    (mismatch_count),
        .o_pending           (translations_pending),
        .o_translation_count (translation_count),
        .o_hit_count         (hit_count),
        .o_fault_count       (fault_count)
    );

    // Output side: after each transaction draw a random output stall (none in steady flow)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
            i_out_stall  <= 1'b0;
        end else if (o_out_valid && !i_out_stall) begin
            stall_draw = steady_flow ? 0 : $urandom_range(0, 4);
            stall_cycles <= stall_draw;
            i_out_stall  <= (stall_draw != 0);
        end else if (stall_cycles > 1) begin
            stall_cycles <= stall_cycles - 1;
        end else begin
            stall_cycles <= 0;
            i_out_stall  <= 1'b0;
        end
    end

    // Watchdog: cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d translations outstanding",
                     $time, translations_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one address after a gap; returns just after the accepting edge
    task automatic send_address(input int unsigned page, input int unsigned offset,
                                input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_logical_address <= ADDR_W'((page % PAGES) * PG_SIZE + offset);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Hold off input until every outstanding translation has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (translations_pending != 0);
        @(posedge i_clk);
    endtask

    function automatic int unsigned draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic int unsigned draw_offset();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? PG_SIZE - 1 : 0;
        return $urandom_range(0, PG_SIZE - 1);
    endfunction

    initial begin
        int unsigned ws_base;
        int unsigned sweep_page;
        int unsigned pick;
        int unsigned page;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: page 0 first (no spurious hit on empty TLB), extremes, hits
        send_address(0, 0, 0);
        send_address(0, 8'hFF, draw_gap());
        send_address(PAGES - 1, 8'hFF, draw_gap());
        send_address(PAGES - 1, 0, draw_gap());
        // fill the remaining TLB slots with fresh pages
        for (int p = 1; p <= ENTRIES - 2; p++) begin
            send_address(p, (p * 17) % PG_SIZE, draw_gap());
        end
        // TLB full: FIFO replacement, then evicted pages walk without a fault
        send_address(8'h80, 8'hAA, draw_gap());
        send_address(0, 8'h55, draw_gap());
        send_address(PAGES - 1, 8'h5A, draw_gap());
        send_address(8'h80, 8'h55, draw_gap());
        wait_for_results();

        // Random: working-set locality, page sweep, near misses and noise
        ws_base    = $urandom_range(0, PAGES - 1);
        sweep_page = ENTRIES;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) steady_flow <= ($urandom_range(0, 9) < 3);
            if (n % 64 == 0) ws_base = $urandom_range(0, PAGES - 1);
            if (n % 500 == 499) wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                page = ws_base + $urandom_range(0, 11);
            end else if (pick < 70) begin
                page       = sweep_page;
                sweep_page = (sweep_page + 1) % PAGES;
            end else if (pick < 85) begin
                page = ws_base + $urandom_range(0, 31);
            end else begin
                page = $urandom_range(0, PAGES - 1);
            end
            send_address(page, draw_offset(), draw_gap());
        end

        // Drain, then allow the pipeline latency to pass
        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("Translated %0d addresses: %0d TLB hits, %0d page faults, %0d table walks",
                 translation_count, hit_count, fault_count,
                 translation_count - hit_count - fault_count);
        $display("Bursts with and without gaps and output stalls; every page demand-mapped");
        if (translations_pending != 0) begin
            $display("%0t: %0d expected translations never arrived", $time, translations_pending);
        end
        if (mismatch_count == 0 && translations_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
